FILE: rtl/nprc_pkg.sv
`timescale 1ns / 1ps
package nprc_pkg;

    localparam int MAX_PIECES_DEF = 64;
    localparam int MAX_STRIP_DEF  = 256;

    localparam logic [8:0] STRIP_RESET = 9'd256;

    // request modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_NO_INDEX = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] piece_width;
        logic [6:0] copies;
        logic [5:0] piece_index;
        logic [7:0] position;
    } t_in_req;

    typedef struct packed {
        logic       reachable;
        logic [1:0] status;
        logic [6:0] pieces_held;
    } t_out_rsp;

    // controller -> datapath
    typedef struct packed {
        logic accept;  // latch incoming request
        logic wr;      // store one copy
        logic rd;      // issue one width read for the query sweep
        logic resp;    // load the response register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic add_loop;   // incoming add stores at least one copy
        logic qry_loop;   // incoming query needs the sweep
        logic left_last;  // last copy being written
        logic k_last;     // last stored piece being read
    } t_dp_sts;

endpackage

FILE: rtl/normal_pattern_reachability_core.sv
`timescale 1ns / 1ps
// Flow: clear, mode 3, an add of zero copies, a rejected add and a query with nothing to
// sweep go straight to the response; an add of N copies makes one store write each; a query
// makes one width store read and shift-OR per piece held, then a drain step, then responds.
// One request in flight; o_in_ready rises with o_out_valid, and the response step waits
// while the response register is not taken.
// Reset (i_rst_n low, synchronous): no pieces held, strip width 256, no response.
module normal_pattern_reachability_core #(
    parameter int MAX_PIECES = nprc_pkg::MAX_PIECES_DEF,
    parameter int MAX_STRIP  = nprc_pkg::MAX_STRIP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: strip width
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_wdata,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nprc_pkg::t_in_req  i_in_req,
    // response channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nprc_pkg::t_out_rsp o_out_rsp
);
    import nprc_pkg::*;

    // Controller sequences each request:
    //   idle  -> latch request, decide overflow / bad index / out of strip
    //   add   -> one copy into the width store per cycle
    //   query -> sweep stored widths; the datapath ORs the reach vector with
    //            itself shifted by each width, skipping the named piece
    //   drain -> last read word folds in
    //   resp  -> load response register once it is free
    t_dp_cmd cmd;
    t_dp_sts sts;

    nprc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Width store, piece count, reach vector and response payload.
    nprc_dp #(
        .MAX_PIECES (MAX_PIECES),
        .MAX_STRIP  (MAX_STRIP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp       (o_out_rsp)
    );

endmodule

FILE: rtl/nprc_ctrl.sv
`timescale 1ns / 1ps
module nprc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  nprc_pkg::t_dp_sts i_sts,
    output nprc_pkg::t_dp_cmd o_cmd
);
    import nprc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_QRY,
        S_DRAIN,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.add_loop) begin
                        n_state = S_ADD;
                    end else if (i_sts.qry_loop) begin
                        n_state = S_QRY;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_ADD: begin
                o_cmd.wr = 1'b1;
                if (i_sts.left_last) begin
                    n_state = S_RESP;
                end
            end
            S_QRY: begin
                o_cmd.rd = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read word folds into the vector here
                n_state = S_RESP;
            end
            S_RESP: begin
                if (slot_free) begin
                    o_cmd.resp  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted request did not start processing");

    a_resp_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && slot_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("response not presented");

endmodule

FILE: rtl/nprc_dp.sv
`timescale 1ns / 1ps
module nprc_dp #(
    parameter int MAX_PIECES = nprc_pkg::MAX_PIECES_DEF,
    parameter int MAX_STRIP  = nprc_pkg::MAX_STRIP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_wdata,
    input  nprc_pkg::t_in_req i_req,
    input  nprc_pkg::t_dp_cmd i_cmd,
    output nprc_pkg::t_dp_sts o_sts,
    output nprc_pkg::t_out_rsp o_rsp
);
    import nprc_pkg::*;

    localparam int AW   = $clog2(MAX_PIECES);
    localparam int CW   = $clog2(MAX_PIECES + 1);
    localparam int SUMW = ((CW > 7) ? CW : 7) + 1;
    localparam int SW   = $clog2(MAX_STRIP);

    logic [8:0]           r_strip;
    logic [CW-1:0]        r_total;
    logic                 r_rd_vld;
    t_in_req              r_req;
    logic [6:0]           r_left;
    logic [CW-1:0]        r_k;
    logic [AW-1:0]        r_rd_k;
    logic [8:0]           r_rd_data;
    logic [MAX_STRIP-1:0] r_reach;
    logic [1:0]           r_status;
    logic                 r_qry_ok;
    t_out_rsp             r_rsp;

    logic [8:0] mem [MAX_PIECES];

    logic          ovf, idx_bad, pos_in_i, pos_in_r, skip;
    logic [CW-1:0] n_k_inc;
    logic [1:0]    n_status;

    assign ovf = (SUMW'(r_total) + SUMW'(i_req.copies)) > SUMW'(MAX_PIECES);
    assign idx_bad = SUMW'(i_req.piece_index) >= SUMW'(r_total);
    assign pos_in_i = ({1'b0, i_req.position} < r_strip)
                   && (int'(i_req.position) < MAX_STRIP);
    assign pos_in_r = ({1'b0, r_req.position} < r_strip)
                   && (int'(r_req.position) < MAX_STRIP);
    assign skip    = SUMW'(r_rd_k) == SUMW'(r_req.piece_index);
    assign n_k_inc = r_k + 1'b1;

    assign o_sts.add_loop  = (i_req.mode == MODE_ADD) && !ovf && (i_req.copies != 7'd0);
    assign o_sts.qry_loop  = (i_req.mode == MODE_QUERY) && !idx_bad && pos_in_i;
    assign o_sts.left_last = (r_left == 7'd1);
    assign o_sts.k_last    = (n_k_inc == r_total);

    always_comb begin
        case (i_req.mode)
            MODE_ADD:   n_status = ovf ? ST_OVERFLOW : ST_OK;
            MODE_QUERY: n_status = idx_bad ? ST_NO_INDEX : ST_OK;
            default:    n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip  <= STRIP_RESET;
            r_total  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_strip <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.accept && i_req.mode == MODE_CLEAR) begin
                r_total <= '0;
            end else if (i_cmd.wr) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= i_req;
            r_left   <= i_req.copies;
            r_k      <= '0;
            r_reach  <= MAX_STRIP'(1);
            r_status <= n_status;
            r_qry_ok <= (i_req.mode == MODE_QUERY) && !idx_bad;
        end else begin
            if (i_cmd.wr) begin
                r_left <= r_left - 1'b1;
            end
            if (i_cmd.rd) begin
                r_k <= n_k_inc;
            end
            // 0/1 knapsack step: each piece shifts the vector once
            if (r_rd_vld && !skip) begin
                r_reach <= r_reach | (r_reach << r_rd_data);
            end
        end
        if (i_cmd.resp) begin
            r_rsp.reachable   <= r_qry_ok && pos_in_r && r_reach[SW'(r_req.position)];
            r_rsp.status      <= r_status;
            r_rsp.pieces_held <= 7'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_total[AW-1:0]] <= r_req.piece_width;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_k[AW-1:0]];
            r_rd_k    <= r_k[AW-1:0];
        end
    end

    assign o_rsp = r_rsp;

    a_wr_in_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> (SUMW'(r_total) < SUMW'(MAX_PIECES)))
        else $error("piece write beyond capacity");

    a_wr_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |=> (r_total == CW'($past(r_total) + 1'b1)))
        else $error("piece count did not advance on write");

endmodule

FILE: bench/normal_pattern_reachability_core_tb.sv
`timescale 1ns / 1ps
module normal_pattern_reachability_core_tb;
    import nprc_pkg::*;

    // mode 3 is not decoded by the block: no state change, plain OK response
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int PIECE_CAP  = 64;
    localparam int STRIP_CAP  = 256;
    localparam int HANG_LIMIT = 4000;   // cycles with no handshake on either side
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 240;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [8:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_req    i_in_req;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_rsp   o_out_rsp;

    normal_pattern_reachability_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the piece list and strip register
    // ------------------------------------------------------------------
    logic [8:0] held_w [PIECE_CAP];
    int         held_n;
    logic [8:0] strip_cfg;

    // responses owed by the block, oldest first
    t_out_rsp   rsp_due_q[$];
    int         err_count;
    bit         idle_on;

    // Strip width actually used: register clamped to the strip capacity.
    function automatic int eff_strip();
        return (strip_cfg > STRIP_CAP) ? STRIP_CAP : int'(strip_cfg);
    endfunction

    // 0/1 knapsack over every held piece except 'skip'. Shifting the whole
    // vector at once reads only old bits, so each piece is used at most once.
    function automatic logic pos_reachable(int skip, int pos);
        int             w;
        int             pw;
        logic [255:0]   vec;
        logic [255:0]   mask;
        w = eff_strip();
        if (pos >= w)
            return 1'b0;
        mask = (w == STRIP_CAP) ? '1 : ((256'd1 << w) - 256'd1);
        vec  = 256'd1;
        for (int k = 0; k < held_n; k++) begin
            pw = int'(held_w[k]);
            if (k == skip || pw == 0 || pw >= w)
                continue;
            vec = vec | ((vec << pw) & mask);
        end
        return vec[pos];
    endfunction

    // Advances the shadow state by one request and returns the response.
    function automatic t_out_rsp compute_response(t_in_req r);
        t_out_rsp rsp;
        rsp.reachable = 1'b0;
        rsp.status    = ST_OK;
        case (r.mode)
            MODE_CLEAR: begin
                held_n = 0;
            end
            MODE_ADD: begin
                if (held_n + int'(r.copies) > PIECE_CAP) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    for (int c = 0; c < int'(r.copies); c++)
                        held_w[held_n + c] = r.piece_width;
                    held_n += int'(r.copies);
                end
            end
            MODE_QUERY: begin
                if (int'(r.piece_index) >= held_n)
                    rsp.status = ST_NO_INDEX;
                else
                    rsp.reachable = pos_reachable(int'(r.piece_index), int'(r.position));
            end
            default: ;
        endcase
        rsp.pieces_held = held_n[6:0];
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct packed {
        bit         is_cfg;     // row writes strip_width instead of a request
        logic [8:0] cfg_val;
        t_in_req    req;
        bit         typed;      // rsp below is checked instead of the predictor
        t_out_rsp   rsp;
    } t_row;

    t_row dir_rows[$];

    function automatic t_in_req req_of(logic [1:0] m, logic [8:0] w, logic [6:0] c,
                                       logic [5:0] idx, logic [7:0] pos);
        t_in_req r;
        r.mode        = m;
        r.piece_width = w;
        r.copies      = c;
        r.piece_index = idx;
        r.position    = pos;
        return r;
    endfunction

    function automatic t_out_rsp rsp_of(logic hit, logic [1:0] st, logic [6:0] n);
        t_out_rsp s;
        s.reachable   = hit;
        s.status      = st;
        s.pieces_held = n;
        return s;
    endfunction

    task automatic row_req(t_in_req r);
        t_row row;
        row = '0;
        row.req = r;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic row_chk(t_in_req r, t_out_rsp s);
        t_row row;
        row = '0;
        row.req   = r;
        row.typed = 1'b1;
        row.rsp   = s;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic row_cfg(logic [8:0] v);
        t_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic build_table();
        // empty list: any query index is not loaded
        row_chk(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd0, 8'd0), rsp_of(1'b0, ST_NO_INDEX, 7'd0));
        row_chk(req_of(MODE_NONE, 9'h1FF, 7'h7F, 6'h3F, 8'hFF), rsp_of(1'b0, ST_OK, 7'd0));
        // zero copies stores nothing
        row_chk(req_of(MODE_ADD, 9'd0, 7'd0, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd0));
        row_chk(req_of(MODE_ADD, 9'd5, 7'd127, 6'd0, 8'd0), rsp_of(1'b0, ST_OVERFLOW, 7'd0));
        row_chk(req_of(MODE_ADD, 9'd1, 7'd3, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd3));
        row_req(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd0, 8'd2));
        row_req(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd0, 8'd3));
        row_chk(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd3, 8'd0), rsp_of(1'b0, ST_NO_INDEX, 7'd3));
        // pieces wider than the strip and zero-width pieces
        row_chk(req_of(MODE_ADD, 9'h1FF, 7'd1, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd4));
        row_chk(req_of(MODE_ADD, 9'd256, 7'd1, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd5));
        row_chk(req_of(MODE_ADD, 9'd0, 7'd2, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd7));
        row_chk(req_of(MODE_ADD, 9'd200, 7'd1, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd8));
        row_req(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd0, 8'd202));
        row_req(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd7, 8'd255));
        // narrow strip: position past the edge
        row_cfg(9'd100);
        row_chk(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd0, 8'd150), rsp_of(1'b0, ST_OK, 7'd8));
        row_req(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd0, 8'd2));
        // zero strip: nothing reachable, not even position 0
        row_cfg(9'd0);
        row_chk(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd1, 8'd0), rsp_of(1'b0, ST_OK, 7'd8));
        // register above the capacity clamps to 256
        row_cfg(9'h1FF);
        row_req(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd7, 8'd203));
        row_chk(req_of(MODE_ADD, 9'd3, 7'd56, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd64));
        row_chk(req_of(MODE_ADD, 9'd1, 7'd1, 6'd0, 8'd0), rsp_of(1'b0, ST_OVERFLOW, 7'd64));
        row_req(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd63, 8'd255));
        row_chk(req_of(MODE_QUERY, 9'd0, 7'd0, 6'd0, 8'd0), rsp_of(1'b1, ST_OK, 7'd64));
        row_chk(req_of(MODE_CLEAR, 9'd0, 7'd0, 6'd0, 8'd0), rsp_of(1'b0, ST_OK, 7'd0));
        row_cfg(9'd256);
    endtask

    // ------------------------------------------------------------------
    // Random requests: mostly clear/add/query sequences that build real
    // piece lists, with noise in the unused fields and some junk requests.
    // ------------------------------------------------------------------
    function automatic t_in_req rand_req();
        t_in_req r;
        int      aw;
        int      sel;
        int      clr_pct;
        aw  = eff_strip();
        r   = req_of(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                     7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)));
        clr_pct = (held_n >= 40) ? 20 : 3;
        sel = $urandom_range(0, 99);
        if (sel < clr_pct) begin
            r.mode = MODE_CLEAR;
        end else if (sel < 35) begin
            r.mode = MODE_ADD;
            sel = $urandom_range(0, 9);
            if (sel < 7)
                r.copies = 7'($urandom_range(1, 6));
            else if (sel < 8 && held_n < PIECE_CAP)
                r.copies = 7'(PIECE_CAP - held_n);     // fill exactly to capacity
            sel = $urandom_range(0, 9);
            if (sel < 7)
                r.piece_width = 9'($urandom_range(1, (aw > 8) ? aw / 4 : 2));
            else if (sel < 8)
                r.piece_width = 9'($urandom_range((aw > 0) ? aw - 1 : 0, aw + 1));
        end else if (sel < 94) begin
            r.mode = MODE_QUERY;
            if (held_n > 0 && $urandom_range(0, 9) < 9)
                r.piece_index = 6'($urandom_range(0, held_n - 1));
            if (aw > 0 && $urandom_range(0, 9) < 8)
                r.position = 8'($urandom_range(0, (aw > STRIP_CAP ? STRIP_CAP : aw) - 1));
        end else begin
            r.mode = MODE_NONE;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Driven at the falling edge, handshake seen at the rising.
    // ------------------------------------------------------------------
    task automatic send_req(t_in_req r, bit typed, t_out_rsp typed_rsp);
        t_out_rsp p;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req   = r;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // the predictor always runs so its state tracks the block
        p = compute_response(r);
        rsp_due_q.insert(rsp_due_q.size(), typed ? typed_rsp : p);
        @(negedge i_clk);
    endtask

    // Hold off until every owed response has come back.
    task automatic drain();
        i_in_valid = 1'b0;
        while (rsp_due_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_strip(logic [8:0] v);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        strip_cfg   = v;
    endtask

    // ------------------------------------------------------------------
    // Response side: random ready stalls, checked at the rising edge
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rsp_due_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR %0t: response with none owed: hit=%0b st=%0d held=%0d",
                             $realtime, o_out_rsp.reachable, o_out_rsp.status,
                             o_out_rsp.pieces_held);
            end else begin
                want = rsp_due_q.pop_front();
                if (o_out_rsp.reachable !== want.reachable ||
                    o_out_rsp.status !== want.status ||
                    o_out_rsp.pieces_held !== want.pieces_held) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR %0t: exp hit=%0b st=%0d held=%0d, got hit=%0b st=%0d held=%0d",
                                 $realtime, want.reachable, want.status, want.pieces_held,
                                 o_out_rsp.reachable, o_out_rsp.status, o_out_rsp.pieces_held);
                end
            end
        end
    end

    // Watchdog: counts cycles while nothing moves on either channel, ends the run at HANG_LIMIT
    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("normal_pattern_reachability_core_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [8:0] strip_plan [RAND_PHASES];
        t_row       row;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_in_req     = '0;
        idle_on      = 1'b1;
        err_count    = 0;
        quiet_cycles = 0;
        held_n       = 0;
        strip_cfg    = STRIP_RESET;
        build_table();

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg)
                write_strip(row.cfg_val);
            else
                send_req(row.req, row.typed, row.rsp);
        end
        drain();

        // random part: one strip setting per phase, last phase runs flat out
        strip_plan[0] = 9'd256;
        strip_plan[1] = 9'd1;
        strip_plan[2] = 9'd2;
        strip_plan[3] = 9'd37;
        strip_plan[4] = 9'($urandom_range(0, 511));
        strip_plan[5] = 9'd100;
        strip_plan[6] = 9'd255;
        strip_plan[7] = 9'd256;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_strip(strip_plan[ph]);
            idle_on = (ph != RAND_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (idle_on && $urandom_range(0, 149) == 0)
                    drain();
                send_req(rand_req(), 1'b0, '0);
            end
        end

        i_in_valid = 1'b0;
        while (rsp_due_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_count == 0)
            $display("normal_pattern_reachability_core_tb: done, clean");
        else
            $display("normal_pattern_reachability_core_tb: done, errors");
        $finish;
    end

endmodule
